/* src/ortc_pkg.sv */
// shared types, codes and helpers for the outstanding request table compactor
// used by ortc_ctrl, ortc_dp and the top level; no dependencies
`default_nettype none

package ortc_pkg;

   localparam int CHUNK_BITS = 8;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_BATCH = 1'b1;

   localparam logic [1:0] TS_SUCCESS    = 2'd0;
   localparam logic [1:0] TS_STATUS_ERR = 2'd1;
   localparam logic [1:0] TS_UNDEFINED  = 2'd2;
   localparam logic [1:0] TS_GEN_ERR    = 2'd3;

   localparam logic [1:0] OPS_OK      = 2'd0;
   localparam logic [1:0] OPS_FULL    = 2'd1;
   localparam logic [1:0] OPS_GEN_ERR = 2'd2;
   localparam logic [1:0] OPS_RESET   = 2'd3;

   typedef struct packed {
      logic        op;
      logic [31:0] entry_tag;
      logic [31:0] request_id;
      logic [63:0] done_mask;
      logic [1:0]  test_status;
   } req_type;

   typedef struct packed {
      logic [1:0]  op_status;
      logic        released;
      logic [31:0] released_tag;
      logic [5:0]  released_slot;
      logic [6:0]  used_count;
      logic [63:0] test_count;
      logic [63:0] single_count;
      logic [63:0] multi_count;
      logic [6:0]  max_batch;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_STATS,
      ST_RELEASE,
      ST_COMPACT,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic       emit;
      logic [1:0] emit_status;
      logic       add;
      logic       batch_inc;
      logic       clear_occ;
      logic       load_mask;
      logic       count_step;
      logic       stats;
      logic       rel_step;
      logic       cmp_step;
      logic       cmp_write;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic count_last;
      logic got_zero;
      logic got_all;
      logic scan_last;
      logic cmp_done;
      logic cmp_copy;
   } status_type;

   function automatic logic [3:0] pop8(input logic [CHUNK_BITS-1:0] bits);
      logic [3:0] sum;
      sum = 4'd0;
      for (int k = 0; k < CHUNK_BITS; k++) begin
         sum = sum + {3'b000, bits[k]};
      end
      return sum;
   endfunction

endpackage

`default_nettype wire

/* src/ortc_ctrl.sv */
// controller state machine for the outstanding request table compactor
// depends on ortc_pkg; drives commands into ortc_dp and reads its status
`default_nettype none

module ortc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_op,
   input  wire logic [1:0]            req_test_status,
   input  wire ortc_pkg::status_type  st,
   output ortc_pkg::cmd_type          cmd,
   output logic                       busy
);

   ortc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ortc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ortc_pkg::ST_IDLE);
      unique case (state_ff)
         ortc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ortc_pkg::OPS_OK;
               if (req_op == ortc_pkg::OP_ADD) begin
                  if (st.full) begin
                     cmd.emit_status = ortc_pkg::OPS_FULL;
                  end else begin
                     cmd.add = 1'b1;
                  end
               end else if (!st.empty) begin
                  cmd.batch_inc = 1'b1;
                  case (req_test_status)
                     ortc_pkg::TS_UNDEFINED: begin
                        cmd.clear_occ   = 1'b1;
                        cmd.emit_status = ortc_pkg::OPS_RESET;
                     end
                     ortc_pkg::TS_GEN_ERR: begin
                        cmd.emit_status = ortc_pkg::OPS_GEN_ERR;
                     end
                     default: begin
                        // success or error in status: walk the batch
                        cmd.emit      = 1'b0;
                        cmd.load_mask = 1'b1;
                        state_in      = ortc_pkg::ST_COUNT;
                     end
                  endcase
               end
            end
         end
         ortc_pkg::ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (st.count_last) begin
               state_in = ortc_pkg::ST_STATS;
            end
         end
         ortc_pkg::ST_STATS: begin
            if (st.got_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ortc_pkg::OPS_OK;
               state_in        = ortc_pkg::ST_IDLE;
            end else begin
               cmd.stats = 1'b1;
               state_in  = ortc_pkg::ST_RELEASE;
            end
         end
         ortc_pkg::ST_RELEASE: begin
            cmd.rel_step = 1'b1;
            if (st.scan_last) begin
               state_in = st.got_all ? ortc_pkg::ST_IDLE : ortc_pkg::ST_COMPACT;
            end
         end
         ortc_pkg::ST_COMPACT: begin
            if (st.cmp_done) begin
               state_in = ortc_pkg::ST_IDLE;
            end else begin
               cmd.cmp_step = 1'b1;
               if (st.cmp_copy) begin
                  state_in = ortc_pkg::ST_COPY;
               end
            end
         end
         ortc_pkg::ST_COPY: begin
            cmd.cmp_write = 1'b1;
            state_in      = ortc_pkg::ST_COMPACT;
         end
         default: begin
            state_in = ortc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/ortc_dp.sv */
// datapath of the outstanding request table compactor: slot memories,
// occupancy, batch statistics, scan pointers and the result register; uses ortc_pkg
`default_nettype none

module ortc_dp #(
   parameter int SLOTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ortc_pkg::req_type     req_data,
   input  wire ortc_pkg::cmd_type     cmd,
   output ortc_pkg::status_type       st,
   output ortc_pkg::rsp_type          rsp_data,
   output logic                       strobe
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int NCHUNK = (SLOTS + ortc_pkg::CHUNK_BITS - 1) / ortc_pkg::CHUNK_BITS;
   localparam int MASK_W = NCHUNK * ortc_pkg::CHUNK_BITS;
   localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   logic [31:0] tag_mem [SLOTS];
   logic [31:0] req_mem [SLOTS];

   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [63:0]      batch_ff, batch_in;
   logic [63:0]      single_ff, single_in;
   logic [63:0]      multi_ff, multi_in;
   logic [CNT_W-1:0] largest_ff, largest_in;

   logic [SLOTS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0] got_ff, got_in;
   logic [CH_W-1:0]  chunk_ff, chunk_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pull_ff, pull_in;
   logic [CNT_W-1:0] rel_cnt_ff, rel_cnt_in;

   logic             strobe_ff, strobe_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_rel_ff, rsp_rel_in;
   logic [5:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [31:0]      tag_rd_ff;
   logic [31:0]      req_rd_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_tag;
   logic [31:0]      wr_req;

   logic [MASK_W-1:0]               mask_wide;
   logic [ortc_pkg::CHUNK_BITS-1:0] chunk_bits;
   logic                            mask_idx;
   logic                            mask_pull;
   logic [CNT_W-1:0]                newcount;

   always_comb begin
      mask_wide  = MASK_W'(mask_ff);
      chunk_bits = ortc_pkg::CHUNK_BITS'(mask_wide >> (int'(chunk_ff) * ortc_pkg::CHUNK_BITS));
      mask_idx   = mask_ff[idx_ff];
      mask_pull  = mask_ff[pull_ff];
      newcount   = n_ff - got_ff;
   end

   always_comb begin
      st.full       = (occ_ff == CNT_W'(SLOTS));
      st.empty      = (occ_ff == '0);
      st.count_last = (chunk_ff == CH_W'(NCHUNK - 1));
      st.got_zero   = (got_ff == '0);
      st.got_all    = (got_ff == n_ff);
      st.scan_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);
      st.cmp_done   = (CNT_W'(idx_ff) == occ_ff);
      st.cmp_copy   = mask_idx && !mask_pull;
   end

   always_comb begin
      occ_in        = occ_ff;
      n_in          = n_ff;
      batch_in      = batch_ff;
      single_in     = single_ff;
      multi_in      = multi_ff;
      largest_in    = largest_ff;
      mask_in       = mask_ff;
      got_in        = got_ff;
      chunk_in      = chunk_ff;
      idx_in        = idx_ff;
      pull_in       = pull_ff;
      rel_cnt_in    = rel_cnt_ff;
      strobe_in     = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_tag        = tag_rd_ff;
      wr_req        = req_rd_ff;

      if (cmd.emit) begin
         strobe_in     = 1'b1;
         rsp_status_in = cmd.emit_status;
         rsp_rel_in    = 1'b0;
         rsp_slot_in   = 6'd0;
         rsp_last_in   = 1'b1;
      end

      if (cmd.add) begin
         wr_en   = 1'b1;
         wr_addr = occ_ff[IDX_W-1:0];
         wr_tag  = req_data.entry_tag;
         wr_req  = req_data.request_id;
         occ_in  = occ_ff + CNT_W'(1);
      end

      if (cmd.batch_inc) begin
         batch_in = batch_ff + 64'd1;
      end

      if (cmd.clear_occ) begin
         occ_in = '0;
      end

      if (cmd.load_mask) begin
         // keep only slots below the current count
         for (int k = 0; k < SLOTS; k++) begin
            mask_in[k] = req_data.done_mask[k] && (CNT_W'(k) < occ_ff);
         end
         n_in     = occ_ff;
         got_in   = '0;
         chunk_in = '0;
      end

      if (cmd.count_step) begin
         got_in   = got_ff + CNT_W'(ortc_pkg::pop8(chunk_bits));
         chunk_in = chunk_ff + CH_W'(1);
      end

      if (cmd.stats) begin
         if (got_ff == CNT_W'(1)) begin
            single_in = single_ff + 64'd1;
         end else begin
            multi_in = multi_ff + 64'd1;
         end
         if (got_ff > largest_ff) begin
            largest_in = got_ff;
         end
         occ_in     = newcount;
         idx_in     = '0;
         pull_in    = newcount[IDX_W-1:0];
         rel_cnt_in = '0;
      end

      if (cmd.rel_step) begin
         if (mask_idx) begin
            rd_en         = 1'b1;
            rd_addr       = idx_ff;
            strobe_in     = 1'b1;
            rsp_status_in = ortc_pkg::OPS_OK;
            rsp_rel_in    = 1'b1;
            rsp_slot_in   = 6'(idx_ff);
            rsp_last_in   = ((rel_cnt_ff + CNT_W'(1)) == got_ff);
            rel_cnt_in    = rel_cnt_ff + CNT_W'(1);
         end
         idx_in = st.scan_last ? '0 : idx_ff + IDX_W'(1);
      end

      if (cmd.cmp_step) begin
         // holes below the new count take the lowest survivors above it
         if (!mask_idx) begin
            idx_in = idx_ff + IDX_W'(1);
         end else if (mask_pull) begin
            pull_in = pull_ff + IDX_W'(1);
         end else begin
            rd_en   = 1'b1;
            rd_addr = pull_ff;
         end
      end

      if (cmd.cmp_write) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_tag  = tag_rd_ff;
         wr_req  = req_rd_ff;
         idx_in  = idx_ff + IDX_W'(1);
         pull_in = pull_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         batch_ff   <= '0;
         single_ff  <= '0;
         multi_ff   <= '0;
         largest_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         batch_ff   <= batch_in;
         single_ff  <= single_in;
         multi_ff   <= multi_in;
         largest_ff <= largest_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      mask_ff       <= mask_in;
      got_ff        <= got_in;
      chunk_ff      <= chunk_in;
      idx_ff        <= idx_in;
      pull_ff       <= pull_in;
      rel_cnt_ff    <= rel_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
         req_mem[wr_addr] <= wr_req;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_rd_ff <= tag_mem[rd_addr];
         req_rd_ff <= req_mem[rd_addr];
      end
   end

   // counters are already final when the first result of an item shows
   always_comb begin
      strobe                 = strobe_ff;
      rsp_data.op_status     = rsp_status_ff;
      rsp_data.released      = rsp_rel_ff;
      rsp_data.released_tag  = rsp_rel_ff ? tag_rd_ff : 32'd0;
      rsp_data.released_slot = rsp_slot_ff;
      rsp_data.used_count    = 7'(occ_ff);
      rsp_data.test_count    = batch_ff;
      rsp_data.single_count  = single_ff;
      rsp_data.multi_count   = multi_ff;
      rsp_data.max_batch     = 7'(largest_ff);
      rsp_data.last          = rsp_last_ff;
   end

endmodule

`default_nettype wire

/* src/outstanding_request_table_compactor.sv */
// Outstanding request table compactor. An add's single result strobes in the
// next cycle; busy stays low, so another transaction may start right away. A
// completion batch with success or error-in-status first counts the completed
// slots eight bits a cycle, then takes a statistics step; if no slot completed,
// it ends there with one result. Otherwise it walks every occupied slot one per
// cycle through the tag memory read port, giving one strobed result per completed
// slot the cycle after its read, then, unless every slot completed, compacts with
// two pointers: a skipped slot takes one step, a moved entry a read and then a
// write (single memory read and write port), and a closing step ends it. Results
// are never held: each one sits on rsp_data for exactly the cycle strobe is high.
// Counter fields already carry the values after the whole transaction.
// top level; depends on ortc_pkg, ortc_ctrl and ortc_dp
`default_nettype none

module outstanding_request_table_compactor #(
   parameter int SLOTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire ortc_pkg::req_type  req_data,
   output logic                    strobe,
   output ortc_pkg::rsp_type       rsp_data
);

   ortc_pkg::cmd_type    cmd;
   ortc_pkg::status_type st;

   ortc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_op          (req_data.op),
      .req_test_status (req_data.test_status),
      .st              (st),
      .cmd             (cmd),
      .busy            (busy)
   );

   ortc_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data),
      .strobe   (strobe)
   );

endmodule

`default_nettype wire

/* dv/outstanding_request_table_compactor_test.sv */
// testbench for outstanding_request_table_compactor: directed and random adds and
// completion batches, checked result by result against a scoreboard that tracks the table
// depends on ortc_pkg and the top level of the block
`default_nettype none

module outstanding_request_table_compactor_test;

   localparam int SLOTS = 64;
   localparam int ITEM_TARGET = 210;
   localparam int REQ_W = $bits(ortc_pkg::req_type);
   // longest batch: count chunks, stats, a walk and a two-pointer compaction
   localparam int DRAIN_CYCLES = (SLOTS + 7) / 8 + 1 + 3 * SLOTS + 40;

   class table_scoreboard;
      localparam int SLOT_COUNT = SLOTS;
      logic [31:0] tags [SLOT_COUNT];
      logic [31:0] reqs [SLOT_COUNT];
      int unsigned occ = 0;
      logic [63:0] batches = '0;
      logic [63:0] singles = '0;
      logic [63:0] multis = '0;
      int unsigned largest = 0;
      ortc_pkg::rsp_type expected_q [$];
      int errors = 0;
      int accepted = 0;
      int checked = 0;
      int full_rejects = 0;

      function int pending();
         return expected_q.size();
      endfunction

      // counter fields always carry the state after the whole transaction
      function void push(logic [1:0] st, logic rel, logic [31:0] tag, int unsigned slot,
                         logic fin);
         ortc_pkg::rsp_type e;
         e.op_status     = st;
         e.released      = rel;
         e.released_tag  = tag;
         e.released_slot = slot[5:0];
         e.used_count    = occ[6:0];
         e.test_count    = batches;
         e.single_count  = singles;
         e.multi_count   = multis;
         e.max_batch     = largest[6:0];
         e.last          = fin;
         expected_q.push_back(e);
      endfunction

      function void note_request(ortc_pkg::req_type r);
         int unsigned n, got, pull, newcount;
         logic [31:0] rel_tag [SLOT_COUNT];
         int unsigned rel_slot [SLOT_COUNT];
         logic [63:0] mask;
         accepted++;
         if (r.op == ortc_pkg::OP_ADD) begin
            if (occ >= SLOT_COUNT) begin
               full_rejects++;
               push(ortc_pkg::OPS_FULL, 1'b0, '0, 0, 1'b1);
            end else begin
               tags[occ] = r.entry_tag;
               reqs[occ] = r.request_id;
               occ++;
               push(ortc_pkg::OPS_OK, 1'b0, '0, 0, 1'b1);
            end
            return;
         end
         if (occ == 0) begin
            push(ortc_pkg::OPS_OK, 1'b0, '0, 0, 1'b1);
            return;
         end
         batches++;
         if (r.test_status == ortc_pkg::TS_UNDEFINED) begin
            occ = 0;
            push(ortc_pkg::OPS_RESET, 1'b0, '0, 0, 1'b1);
            return;
         end
         if (r.test_status == ortc_pkg::TS_GEN_ERR) begin
            push(ortc_pkg::OPS_GEN_ERR, 1'b0, '0, 0, 1'b1);
            return;
         end
         n = occ;
         mask = r.done_mask;
         if (n < 64) mask &= (64'd1 << n) - 64'd1;
         got = 0;
         for (int i = 0; i < n; i++) begin
            if (mask[i]) begin
               rel_tag[got]  = tags[i];
               rel_slot[got] = i;
               got++;
            end
         end
         if (got == 0) begin
            push(ortc_pkg::OPS_OK, 1'b0, '0, 0, 1'b1);
            return;
         end
         if (got == 1) singles++;
         else multis++;
         if (got > largest) largest = got;
         if (got >= n) begin
            occ = 0;
         end else begin
            // fill holes below the new count from the lowest survivors above it
            newcount = n - got;
            pull = newcount;
            for (int i = 0; i < newcount; i++) begin
               if (!mask[i]) continue;
               while (pull < n && mask[pull]) pull++;
               if (pull >= n) break;
               tags[i] = tags[pull];
               reqs[i] = reqs[pull];
               pull++;
            end
            occ = newcount;
         end
         for (int i = 0; i < got; i++)
            push(ortc_pkg::OPS_OK, 1'b1, rel_tag[i], rel_slot[i], (i + 1 == got));
      endfunction

      function void compare_field(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $error("%s: expected %0h, actual %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(ortc_pkg::rsp_type a);
         ortc_pkg::rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected, released_tag %0h", a.released_tag);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("op_status", 64'(e.op_status), 64'(a.op_status));
         compare_field("released", 64'(e.released), 64'(a.released));
         compare_field("released_tag", 64'(e.released_tag), 64'(a.released_tag));
         compare_field("released_slot", 64'(e.released_slot), 64'(a.released_slot));
         compare_field("used_count", 64'(e.used_count), 64'(a.used_count));
         compare_field("test_count", e.test_count, a.test_count);
         compare_field("single_count", e.single_count, a.single_count);
         compare_field("multi_count", e.multi_count, a.multi_count);
         compare_field("max_batch", 64'(e.max_batch), 64'(a.max_batch));
         compare_field("last", 64'(e.last), 64'(a.last));
      endfunction
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ortc_pkg::req_type req_data = '0;
   logic              strobe;
   ortc_pkg::rsp_type rsp_data;

   table_scoreboard sb;
   int burst_left = 0;

   outstanding_request_table_compactor #(.SLOTS(SLOTS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .strobe   (strobe),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   // sampled at the edge, before any nonblocking update of this step
   always @(posedge clock) begin
      if (!reset) begin
         if (strobe === 1'b1) sb.check_result(rsp_data);
         if (start && busy === 1'b0) sb.note_request(req_data);
      end
   end

   function automatic ortc_pkg::req_type make_add(logic [31:0] tag, logic [31:0] id);
      ortc_pkg::req_type t;
      t.op          = ortc_pkg::OP_ADD;
      t.entry_tag   = tag;
      t.request_id  = id;
      t.done_mask   = {$urandom, $urandom};
      t.test_status = 2'($urandom);
      return t;
   endfunction

   function automatic ortc_pkg::req_type make_batch(logic [63:0] mask, logic [1:0] st);
      ortc_pkg::req_type t;
      t.op          = ortc_pkg::OP_BATCH;
      t.entry_tag   = $urandom;
      t.request_id  = $urandom;
      t.done_mask   = mask;
      t.test_status = st;
      return t;
   endfunction

   // hold the transaction until it is taken, then maybe idle a while
   task automatic send_transaction(ortc_pkg::req_type t);
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy !== 1'b0);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start    <= 1'b0;
         req_data <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // one idle edge first so the last accepted transaction is already noted
   task automatic wait_for_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic send_random(int add_pct);
      logic [31:0] tag;
      logic [63:0] mask;
      logic [1:0]  st;
      int          r;
      if ($urandom_range(0, 99) < add_pct) begin
         r = $urandom_range(0, 9);
         tag = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         send_transaction(make_add(tag, (r == 1) ? 32'hFFFF_FFFF : $urandom));
      end else begin
         r = $urandom_range(0, 99);
         st = (r < 45) ? ortc_pkg::TS_SUCCESS : (r < 85) ? ortc_pkg::TS_STATUS_ERR :
              (r < 93) ? ortc_pkg::TS_GEN_ERR : ortc_pkg::TS_UNDEFINED;
         case ($urandom_range(0, 4))
            0: mask = {$urandom, $urandom};
            1: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: mask = 64'd1 << $urandom_range(0, (sb.occ > 0) ? sb.occ - 1 : 0);
            3: mask = ~64'd0;
            default: mask = ({$urandom, $urandom} & {$urandom, $urandom}) |
                            (64'd1 << $urandom_range(0, 63));
         endcase
         send_transaction(make_batch(mask, st));
      end
   endtask

   initial begin
      int add_pct;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme values, each status, single and multi batches
      send_transaction(make_batch(~64'd0, ortc_pkg::TS_SUCCESS));
      send_transaction(make_add(32'h0, 32'h0));
      send_transaction(make_add(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_transaction(make_add(32'h5A5A_A5A5, 32'hA5A5_5A5A));
      send_transaction(make_add(32'h1234_5678, 32'h8765_4321));
      send_transaction(make_batch(64'd0, ortc_pkg::TS_SUCCESS));
      // only bits at or above the count: nothing completes
      send_transaction(make_batch(64'hFFFF_FFFF_FFFF_FFF0, ortc_pkg::TS_STATUS_ERR));
      send_transaction(make_batch(~64'd0, ortc_pkg::TS_GEN_ERR));
      send_transaction(make_batch(64'h2, ortc_pkg::TS_STATUS_ERR));
      send_transaction(make_batch(64'h5, ortc_pkg::TS_SUCCESS));
      send_transaction(make_add(32'hDEAD_0001, 32'h1));
      send_transaction(make_add(32'hDEAD_0002, 32'h2));
      send_transaction(make_add(32'hDEAD_0003, 32'h3));
      send_transaction(make_batch(~64'd0, ortc_pkg::TS_SUCCESS));
      send_transaction(make_add(32'hBEEF_0001, 32'h10));
      send_transaction(make_add(32'hBEEF_0002, 32'h20));
      send_transaction(make_add(32'hBEEF_0003, 32'h30));
      send_transaction(make_batch(64'h1, ortc_pkg::TS_UNDEFINED));
      send_transaction(make_batch(64'h1, ortc_pkg::TS_UNDEFINED));
      send_transaction(make_add(32'h8000_0000, 32'h7FFF_FFFF));
      send_transaction(make_batch(64'h1, ortc_pkg::TS_SUCCESS));

      add_pct = 60;
      while (sb.accepted < ITEM_TARGET / 2) begin
         if (sb.accepted % 20 == 0) add_pct = 25 * $urandom_range(1, 3) + 15;
         send_random(add_pct);
      end

      // pause until the table is quiet, then fill it, overflow it and drain it at once
      wait_for_quiet();
      @(posedge clock);
      while (sb.occ < SLOTS) send_transaction(make_add($urandom, $urandom));
      send_transaction(make_add($urandom, $urandom));
      send_transaction(make_add(32'hFFFF_FFFF, 32'h0));
      send_transaction(make_batch(~64'd0, ortc_pkg::TS_SUCCESS));

      while (sb.accepted < ITEM_TARGET) begin
         if (sb.accepted % 20 == 0) add_pct = 25 * $urandom_range(1, 3) + 15;
         send_random(add_pct);
      end

      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d transactions and checked %0d results, %0d adds refused when full",
               sb.accepted, sb.checked, sb.full_rejects);
      $display("%0d batches counted, %0d single, %0d multi, widest batch %0d slots",
               sb.batches, sb.singles, sb.multis, sb.largest);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
